// ----- rtl/quad_point_to_master_coords_assert.svh -----
// Assertion macros for the quad point mapper
`ifndef QUAD_POINT_TO_MASTER_COORDS_ASSERT_SVH
`define QUAD_POINT_TO_MASTER_COORDS_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define QPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/qpm_pkg.sv -----
// Package: shared types for the quad point mapper
package qpm_pkg;
  typedef struct packed {
    logic inside_res;
    logic degenerate;
    logic upper_half;
  } qpm_flags_t;
endpackage

// ----- rtl/qpm_front.sv -----
// Front end: side test, triangle selection and Cramer terms
module qpm_front import qpm_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   v1x, v1y, v2x, v2y, v3x, v3y, v4x, v4y, px, py,
  output logic                            f_valid,
  input  logic                            f_ready,
  output logic signed [4*COORD_WIDTH+3:0] f_det,
  output logic signed [4*COORD_WIDTH+3:0] f_nxi,
  output logic signed [4*COORD_WIDTH+3:0] f_neta,
  output logic                            f_upper
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 2;
  localparam int PW = 2 * DW;
  localparam int NW = 4 * W + 4;
  typedef logic signed [DW-1:0] d_t;
  typedef logic signed [PW-1:0] p_t;

  // stage 1: side test products
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic adv;
  p_t s_t1_r, s_t2_r;
  d_t ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r, apx_r, apy_r;
  assign adv = !s4_v_r || f_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r; s4_v_r <= s3_v_r;
    end
  end

  d_t a_r, b_r, c_r, d_r, dx_r, dy_r;
  logic up2_r, up3_r, up4_r;
  p_t ad_r, bc_r, ddx_r, cdy_r, ady_r, bdx_r;
  logic signed [PW:0] det_r, nxi_r, neta_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s_t1_r <= p_t'(d_t'(v4y) - d_t'(v2y)) * p_t'(d_t'(px) - d_t'(v2x));
      s_t2_r <= p_t'(d_t'(v4x) - d_t'(v2x)) * p_t'(d_t'(py) - d_t'(v2y));
      ax1_r <= d_t'(v1x); ay1_r <= d_t'(v1y); ax2_r <= d_t'(v2x); ay2_r <= d_t'(v2y);
      ax3_r <= d_t'(v3x); ay3_r <= d_t'(v3y); ax4_r <= d_t'(v4x); ay4_r <= d_t'(v4y);
      apx_r <= d_t'(px); apy_r <= d_t'(py);
      up2_r <= (s_t1_r > s_t2_r);
      if (s_t1_r > s_t2_r) begin
        a_r <= ax3_r - ax4_r; b_r <= ay3_r - ay4_r;
        c_r <= ax3_r - ax2_r; d_r <= ay3_r - ay2_r;
        dx_r <= apx_r + ax3_r - ax2_r - ax4_r;
        dy_r <= apy_r + ay3_r - ay2_r - ay4_r;
      end else begin
        a_r <= ax2_r - ax1_r; b_r <= ay2_r - ay1_r;
        c_r <= ax4_r - ax1_r; d_r <= ay4_r - ay1_r;
        dx_r <= apx_r - ax1_r; dy_r <= apy_r - ay1_r;
      end
      up3_r <= up2_r;
      ad_r <= p_t'(a_r) * p_t'(d_r);  bc_r <= p_t'(b_r) * p_t'(c_r);
      ddx_r <= p_t'(d_r) * p_t'(dx_r); cdy_r <= p_t'(c_r) * p_t'(dy_r);
      ady_r <= p_t'(a_r) * p_t'(dy_r); bdx_r <= p_t'(b_r) * p_t'(dx_r);
      up4_r <= up3_r;
      det_r  <= {ad_r[PW-1], ad_r} - {bc_r[PW-1], bc_r};
      nxi_r  <= {ddx_r[PW-1], ddx_r} - {cdy_r[PW-1], cdy_r};
      neta_r <= {ady_r[PW-1], ady_r} - {bdx_r[PW-1], bdx_r};
    end
  end

  assign f_valid = s4_v_r;
  assign f_det   = NW'(det_r);
  assign f_nxi   = NW'(nxi_r);
  assign f_neta  = NW'(neta_r);
  assign f_upper = up4_r;
endmodule

// ----- rtl/qpm_fifo.sv -----
// Short queue between front and back ends
module qpm_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- rtl/qpm_back.sv -----
// Back end: pipelined restoring divider, saturation and flags
module qpm_back import qpm_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            b_valid,
  output logic                            b_ready,
  input  logic signed [4*COORD_WIDTH+3:0] b_det,
  input  logic signed [4*COORD_WIDTH+3:0] b_nxi,
  input  logic signed [4*COORD_WIDTH+3:0] b_neta,
  input  logic                            b_upper,
  output logic                            o_valid,
  input  logic                            o_ready,
  output logic signed [COORD_WIDTH-1:0]   o_xi,
  output logic signed [COORD_WIDTH-1:0]   o_eta,
  output qpm_flags_t                      o_flags
);
  localparam int W  = COORD_WIDTH;
  localparam int NW = 4 * W + 4;
  // quotient bits kept: enough to see saturation
  localparam int QB = W + 1;
  // scaled numerator magnitude width
  localparam int MW = NW + FRAC_BITS;
  localparam int ST = QB;
  // signed output range at the width of the signed quotient
  localparam logic signed [QB+1:0] QMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [QB+1:0] QMIN = {4'b1111, {(W-1){1'b0}}};
  typedef logic [MW-1:0] m_t;
  typedef logic [QB-1:0] q_t;

  logic adv;
  logic v_r [ST+1];
  assign adv = !v_r[ST] || o_ready;
  assign b_ready = adv;

  // per stage payload: two lanes sharing divisor magnitude
  m_t   den_r [ST+1];
  m_t   rx_r  [ST+1], re_r [ST+1];
  m_t   nx_r  [ST+1], ne_r [ST+1];
  q_t   qx_r  [ST+1], qe_r [ST+1];
  logic ovx_r [ST+1], ove_r [ST+1];
  logic sx_r [ST+1], se_r [ST+1], zx_r [ST+1], ze_r [ST+1];
  logic dz_r [ST+1], up_r [ST+1];

  m_t nxm, nem, dm;
  always_comb begin
    nxm = m_t'(b_nxi < 0 ? -b_nxi : b_nxi) << FRAC_BITS;
    nem = m_t'(b_neta < 0 ? -b_neta : b_neta) << FRAC_BITS;
    dm  = m_t'(b_det < 0 ? -b_det : b_det);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= b_valid;
      for (int i = 1; i <= ST; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Stage 0: remainder starts with numerator bits above the quotient window;
  // if they already reach the divisor the quotient is out of range.
  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= dm;
      nx_r[0] <= nxm << (MW - QB);  ne_r[0] <= nem << (MW - QB);
      rx_r[0] <= nxm >> QB;         re_r[0] <= nem >> QB;
      ovx_r[0] <= (nxm >> QB) >= dm; ove_r[0] <= (nem >> QB) >= dm;
      qx_r[0] <= '0; qe_r[0] <= '0;
      sx_r[0] <= (b_nxi < 0) ^ (b_det < 0); se_r[0] <= (b_neta < 0) ^ (b_det < 0);
      zx_r[0] <= b_nxi == 0; ze_r[0] <= b_neta == 0;
      dz_r[0] <= b_det == 0; up_r[0] <= b_upper;
      for (int i = 1; i <= ST; i++) begin
        m_t tx, te;
        tx = {rx_r[i-1][MW-2:0], nx_r[i-1][MW-1]};
        te = {re_r[i-1][MW-2:0], ne_r[i-1][MW-1]};
        den_r[i] <= den_r[i-1];
        nx_r[i] <= nx_r[i-1] << 1; ne_r[i] <= ne_r[i-1] << 1;
        rx_r[i] <= (tx >= den_r[i-1]) ? tx - den_r[i-1] : tx;
        re_r[i] <= (te >= den_r[i-1]) ? te - den_r[i-1] : te;
        qx_r[i] <= {qx_r[i-1][QB-2:0], tx >= den_r[i-1]};
        qe_r[i] <= {qe_r[i-1][QB-2:0], te >= den_r[i-1]};
        ovx_r[i] <= ovx_r[i-1]; ove_r[i] <= ove_r[i-1];
        sx_r[i] <= sx_r[i-1]; se_r[i] <= se_r[i-1];
        zx_r[i] <= zx_r[i-1]; ze_r[i] <= ze_r[i-1];
        dz_r[i] <= dz_r[i-1]; up_r[i] <= up_r[i-1];
      end
    end
  end

  function automatic logic signed [W-1:0] fin(input q_t q, input logic rem_nz,
                                               input logic ov, input logic neg,
                                               input logic nz, input logic dz);
    logic signed [QB+1:0] v;
    v = {2'b00, q};
    if (neg) v = -v - (QB+2)'(rem_nz);
    if (dz)
      fin = nz ? '0 : (neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    else if (ov)
      fin = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else if (v > QMAX)
      fin = {1'b0, {(W-1){1'b1}}};
    else if (v < QMIN)
      fin = {1'b1, {(W-1){1'b0}}};
    else
      fin = v[W-1:0];
  endfunction

  logic signed [W-1:0] xi, eta, one;
  assign xi  = fin(qx_r[ST], rx_r[ST] != '0, ovx_r[ST], sx_r[ST], zx_r[ST], dz_r[ST]);
  assign eta = fin(qe_r[ST], re_r[ST] != '0, ove_r[ST], se_r[ST], ze_r[ST], dz_r[ST]);
  assign one = W'(1) << FRAC_BITS;

  assign o_valid = v_r[ST];
  assign o_xi = xi;
  assign o_eta = eta;
  assign o_flags.degenerate = dz_r[ST];
  assign o_flags.upper_half = up_r[ST];
  assign o_flags.inside_res = !dz_r[ST] && xi >= 0 && xi <= one && eta >= 0 && eta <= one;
endmodule

// ----- rtl/quad_point_to_master_coords.sv -----
// Top level: quad point to master coordinate mapper
// One word in, one word out, one item per cycle sustained while out_tready
// stays high. The front end registers side test products, triangle select,
// Cramer products and differences; a two-entry queue decouples it from the
// back end, a pipelined restoring divider of COORD_WIDTH+2 stages (one
// quotient bit per stage after the first, two lanes sharing the divisor). A
// zero determinant sets degenerate; outputs with nonzero numerators saturate.
module quad_point_to_master_coords import qpm_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, v4_x, v4_y, pt_x, pt_y (lowest first)
  input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // master_xi, master_eta, inside_res, degenerate (lowest first)
  output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] out_tdata,
  // upper_half
  output logic out_tuser
);
  localparam int W  = COORD_WIDTH;
  localparam int NW = 4 * W + 4;
  localparam int OW = ((2*W+2+7)/8)*8;

  logic f_valid, f_ready, q_valid, q_ready, f_upper, q_upper;
  logic signed [NW-1:0] f_det, f_nxi, f_neta;
  logic [3*NW:0] q_data;
  logic signed [W-1:0] xi, eta;
  qpm_flags_t flags;

  qpm_front #(.COORD_WIDTH(W)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .v1x(in_tdata[0*W +: W]), .v1y(in_tdata[1*W +: W]),
    .v2x(in_tdata[2*W +: W]), .v2y(in_tdata[3*W +: W]),
    .v3x(in_tdata[4*W +: W]), .v3y(in_tdata[5*W +: W]),
    .v4x(in_tdata[6*W +: W]), .v4y(in_tdata[7*W +: W]),
    .px(in_tdata[8*W +: W]),  .py(in_tdata[9*W +: W]),
    .f_valid, .f_ready, .f_det, .f_nxi, .f_neta, .f_upper
  );

  qpm_fifo #(.DW(3*NW+1)) u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_upper, f_neta, f_nxi, f_det}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );
  assign q_upper = q_data[3*NW];

  qpm_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .b_valid(q_valid), .b_ready(q_ready),
    .b_det(q_data[NW-1:0]), .b_nxi(q_data[2*NW-1:NW]), .b_neta(q_data[3*NW-1:2*NW]),
    .b_upper(q_upper),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_xi(xi), .o_eta(eta), .o_flags(flags)
  );

  assign out_tdata = OW'({flags.degenerate, flags.inside_res, eta, xi});
  assign out_tuser = flags.upper_half;
endmodule

// ----- rtl/qpm_checker.sv -----
// Port-level checker for the quad point mapper, bound to the top level
`include "quad_point_to_master_coords_assert.svh"
module qpm_checker #(
  parameter int OW = 72
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [OW-1:0] out_tdata
);
  localparam int W = (OW - 8) / 2;
  `QPM_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `QPM_ASSERT_IMP(a_excl, out_tvalid, !(out_tdata[2*W] && out_tdata[2*W+1]), "inside and degenerate")
  `QPM_ASSERT_IMP(a_ins, out_tvalid && out_tdata[2*W], !out_tdata[W-1] && !out_tdata[2*W-1], "inside with negative coordinate")
endmodule

bind quad_point_to_master_coords qpm_checker #(.OW(OW)) u_qpm_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
